/* rtl/sequential_list_table_macros.svh */
`ifndef SEQUENTIAL_LIST_TABLE_MACROS_SVH
`define SEQUENTIAL_LIST_TABLE_MACROS_SVH

// same-cycle implication on clock, quiet during reset
`define SLT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on clock, quiet during reset
`define SLT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/slt_pkg.sv */
`timescale 1ns / 1ps

package slt_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = IDX_W + 1;
   localparam int VAL_W    = 32;

   typedef enum logic [1:0] {
      FN_INSERT = 2'd0,
      FN_ERASE  = 2'd1,
      FN_FIND   = 2'd2,
      FN_MODIFY = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_ERASE,
      CMD_MODIFY,
      CMD_COMPARE,
      CMD_SCAN
   } cmd_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic [IDX_W-1:0]         pos;
      logic [CNT_W-1:0]         count;
      logic signed [VAL_W-1:0]  value;
   } ctrl_type;

endpackage

/* rtl/slt_cell.sv */
`timescale 1ns / 1ps

module slt_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [slt_pkg::IDX_W-1:0]             cell_index,
   input  slt_pkg::ctrl_type                     ctrl,
   input  logic signed [slt_pkg::VAL_W-1:0]      lower_entry,
   input  logic signed [slt_pkg::VAL_W-1:0]      upper_entry,
   input  logic                                  upper_match,
   output logic signed [slt_pkg::VAL_W-1:0]      entry,
   output logic                                  match
);

   logic signed [slt_pkg::VAL_W-1:0] entry_ff, entry_in;
   logic                             match_ff, match_in;

   always_comb begin
      entry_in = entry_ff;
      match_in = match_ff;
      unique case (ctrl.cmd)
         slt_pkg::CMD_INSERT: begin
            if (cell_index > ctrl.pos) begin
               entry_in = lower_entry;
            end else if (cell_index == ctrl.pos) begin
               entry_in = ctrl.value;
            end
         end
         slt_pkg::CMD_ERASE: begin
            if (cell_index >= ctrl.pos) begin
               entry_in = upper_entry;
            end
         end
         slt_pkg::CMD_MODIFY: begin
            if (cell_index == ctrl.pos) begin
               entry_in = ctrl.value;
            end
         end
         slt_pkg::CMD_COMPARE: begin
            match_in = (entry_ff == ctrl.value) && ({1'b0, cell_index} < ctrl.count);
         end
         slt_pkg::CMD_SCAN: begin
            match_in = upper_match;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

/* rtl/sequential_list_table.sv */
// Packed ordered list of signed 32-bit words held in a row of 256 cells, one entry per
// cell. A request is taken when start is high and busy is low; busy stays high until the
// result has been issued. Insert, erase and modify finish in the EXEC state that follows
// the taken request (all cells shift or write in parallel), after which rsp_strobe is
// registered as the block returns to IDLE. Find compares every cell at once and then
// walks the match flags down the cell chain one cell per cycle until a hit or the end
// of the list; find on an empty list misses without a walk. The result is on the rsp_
// ports for exactly one cycle with rsp_strobe high and cannot be held off by the
// receiver; a new request may be started in that same cycle. Errors go to rsp_status.
`timescale 1ns / 1ps

`include "sequential_list_table_macros.svh"

module sequential_list_table (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_func,
   input  logic [slt_pkg::CNT_W-1:0]             req_position,
   input  logic signed [slt_pkg::VAL_W-1:0]      req_value,
   output logic                                  rsp_strobe,
   output logic [1:0]                            rsp_status,
   output logic [slt_pkg::IDX_W-1:0]             rsp_found_index,
   output logic [slt_pkg::CNT_W-1:0]             rsp_length
);

   typedef enum logic [1:0] {
      IDLE,
      EXEC,
      SCAN
   } state_type;

   state_type                           state_ff, state_in;
   slt_pkg::func_type                   func_ff, func_in;
   logic [slt_pkg::CNT_W-1:0]           pos_ff, pos_in;
   logic signed [slt_pkg::VAL_W-1:0]    value_ff, value_in;
   logic [slt_pkg::CNT_W-1:0]           count_ff, count_in;
   logic [slt_pkg::IDX_W-1:0]           scan_ff, scan_in;
   logic                                strobe_ff, strobe_in;
   slt_pkg::status_type                 status_ff, status_in;
   logic [slt_pkg::IDX_W-1:0]           index_ff, index_in;
   logic [slt_pkg::CNT_W-1:0]           length_ff, length_in;

   slt_pkg::ctrl_type                   cell_ctrl;
   logic signed [slt_pkg::VAL_W-1:0]    entry_bus [slt_pkg::CAPACITY];
   logic [slt_pkg::CAPACITY-1:0]        match_bus;
   logic                                accept;

   assign accept = start && (state_ff == IDLE);

   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      pos_in    = pos_ff;
      value_in  = value_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      index_in  = index_ff;
      length_in = length_ff;

      cell_ctrl.cmd   = slt_pkg::CMD_HOLD;
      cell_ctrl.pos   = pos_ff[slt_pkg::IDX_W-1:0];
      cell_ctrl.count = count_ff;
      cell_ctrl.value = value_ff;

      unique case (state_ff)
         IDLE: begin
            if (start) begin
               func_in  = slt_pkg::func_type'(req_func);
               pos_in   = req_position;
               value_in = req_value;
               state_in = EXEC;
            end
         end
         EXEC: begin
            status_in = slt_pkg::ST_OK;
            index_in  = '0;
            state_in  = IDLE;
            strobe_in = 1'b1;
            unique case (func_ff)
               slt_pkg::FN_INSERT: begin
                  if (count_ff >= slt_pkg::CNT_W'(slt_pkg::CAPACITY)) begin
                     status_in = slt_pkg::ST_FULL;
                  end else if (pos_ff > count_ff) begin
                     status_in = slt_pkg::ST_RANGE;
                  end else begin
                     cell_ctrl.cmd = slt_pkg::CMD_INSERT;
                     count_in      = count_ff + slt_pkg::CNT_W'(1);
                  end
               end
               slt_pkg::FN_ERASE: begin
                  if (pos_ff >= count_ff) begin
                     status_in = slt_pkg::ST_RANGE;
                  end else begin
                     cell_ctrl.cmd = slt_pkg::CMD_ERASE;
                     count_in      = count_ff - slt_pkg::CNT_W'(1);
                  end
               end
               slt_pkg::FN_MODIFY: begin
                  if (pos_ff >= count_ff) begin
                     status_in = slt_pkg::ST_RANGE;
                  end else begin
                     cell_ctrl.cmd = slt_pkg::CMD_MODIFY;
                  end
               end
               slt_pkg::FN_FIND: begin
                  if (count_ff == '0) begin
                     status_in = slt_pkg::ST_MISSING;
                  end else begin
                     cell_ctrl.cmd = slt_pkg::CMD_COMPARE;
                     scan_in       = '0;
                     strobe_in     = 1'b0;
                     state_in      = SCAN;
                  end
               end
               default: begin
               end
            endcase
            length_in = count_in;
         end
         SCAN: begin
            if (match_bus[0]) begin
               status_in = slt_pkg::ST_OK;
               index_in  = scan_ff;
               length_in = count_ff;
               strobe_in = 1'b1;
               state_in  = IDLE;
            end else if ((slt_pkg::CNT_W'({1'b0, scan_ff}) + slt_pkg::CNT_W'(1))
                         >= count_ff) begin
               status_in = slt_pkg::ST_MISSING;
               index_in  = '0;
               length_in = count_ff;
               strobe_in = 1'b1;
               state_in  = IDLE;
            end else begin
               cell_ctrl.cmd = slt_pkg::CMD_SCAN;
               scan_in       = scan_ff + slt_pkg::IDX_W'(1);
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      pos_ff    <= pos_in;
      value_ff  <= value_in;
      scan_ff   <= scan_in;
      status_ff <= status_in;
      index_ff  <= index_in;
      length_ff <= length_in;
      if (reset) begin
         state_ff  <= IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   genvar g;
   generate
      for (g = 0; g < slt_pkg::CAPACITY; g++) begin : g_cell
         logic signed [slt_pkg::VAL_W-1:0] lower_entry;
         logic signed [slt_pkg::VAL_W-1:0] upper_entry;
         logic                             upper_match;

         if (g == 0) begin : g_first
            assign lower_entry = '0;
         end else begin : g_lower
            assign lower_entry = entry_bus[g-1];
         end

         if (g == slt_pkg::CAPACITY - 1) begin : g_last
            assign upper_entry = '0;
            assign upper_match = 1'b0;
         end else begin : g_upper
            assign upper_entry = entry_bus[g+1];
            assign upper_match = match_bus[g+1];
         end

         slt_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cell_index  (slt_pkg::IDX_W'(g)),
            .ctrl        (cell_ctrl),
            .lower_entry (lower_entry),
            .upper_entry (upper_entry),
            .upper_match (upper_match),
            .entry       (entry_bus[g]),
            .match       (match_bus[g])
         );
      end
   endgenerate

   assign busy            = (state_ff != IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_found_index = index_ff;
   assign rsp_length      = length_ff;

   `SLT_ASSERT_NOW(a_count_cap, 1'b1, count_ff <= slt_pkg::CNT_W'(slt_pkg::CAPACITY), "count above capacity")
   `SLT_ASSERT_NOW(a_strobe_idle, strobe_ff, state_ff == IDLE, "result issued while busy")
   `SLT_ASSERT_NEXT(a_accept_exec, accept, state_ff == EXEC, "taken word did not reach execute")
   `SLT_ASSERT_NOW(a_full_count, strobe_ff && (status_ff == slt_pkg::ST_FULL), length_ff == slt_pkg::CNT_W'(slt_pkg::CAPACITY), "full flagged below capacity")
   `SLT_ASSERT_NOW(a_index_zero, strobe_ff && (status_ff != slt_pkg::ST_OK), index_ff == '0, "index set on failed request")

endmodule
